/* design/tcpcm_pkg.sv */
package tcpcm_pkg;

	// field and register widths
	localparam int VOLT_W    = 15;
	localparam int CUR_W     = 16;
	localparam int CFG_W     = 15;
	localparam int CFG_IDX_W = 1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_DETECT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE          = 1'd1;

	localparam logic [CFG_W-1:0] SOURCE_DETECT_RESET = 15'd3000;
	localparam logic [CFG_W-1:0] IDLE_RESET          = 15'd1000;

	// item codes
	localparam logic KIND_TICK   = 1'b0;
	localparam logic KIND_CLEAR  = 1'b1;
	localparam logic RES_SUMMARY = 1'b0;
	localparam logic RES_COLUMN  = 1'b1;

	// source codes
	localparam logic [1:0] SRC_CH1  = 2'd0;
	localparam logic [1:0] SRC_CH2  = 2'd1;
	localparam logic [1:0] SRC_CH3  = 2'd2;
	localparam logic [1:0] SRC_NONE = 2'd3;

	// scale constants
	localparam int unsigned POWER_X100_DIV  = 10000;
	localparam int unsigned CURRENT_FULL_MA = 10000;
	localparam int unsigned POWER_FULL_X10  = 1000;
	localparam int unsigned MAS_PER_MAH     = 3600;
	localparam int unsigned TICKS_PER_S     = 5;
	localparam logic [19:0] TOTAL_CLAMP     = 20'd999999;
	localparam logic [9:0]  CHAN_CLAMP      = 10'd999;

	// v*|i| stays below 2^30
	localparam int PROD_W = 30;

	// v*|i| / 10000 by reciprocal, exact over PROD_W bits
	localparam int T_W     = 17;
	localparam int T_SHIFT = PROD_W + $clog2(POWER_X100_DIV);
	localparam logic [PROD_W:0] T_RECIP =
		(PROD_W+1)'(((64'd1 << T_SHIFT) + 64'(POWER_X100_DIV) - 64'd1) / 64'(POWER_X100_DIV));

	// (v*|i| / 10000) / 10 gives v*|i| / 100000
	localparam int P10_W     = 14;
	localparam int P10_SHIFT = T_W + 4;
	localparam logic [T_W:0] P10_RECIP =
		(T_W+1)'(((64'd1 << P10_SHIFT) + 64'd9) / 64'd10);

	// |i| / 5 for the charge step
	localparam int QA_W     = 13;
	localparam int Q5_SHIFT = CUR_W + $clog2(TICKS_PER_S);
	localparam logic [CUR_W:0] Q5_RECIP =
		(CUR_W+1)'(((64'd1 << Q5_SHIFT) + 64'(TICKS_PER_S) - 64'd1) / 64'(TICKS_PER_S));

	// charge kept as quotient and remainder of 3600; 2^32 splits the same way
	localparam int MAH_Q_W = 21;
	localparam int MAH_R_W = 12;
	localparam int unsigned WRAP_Q = int'((64'd1 << 32) / 64'(MAS_PER_MAH));
	localparam int unsigned WRAP_R = int'((64'd1 << 32) % 64'(MAS_PER_MAH));

	typedef struct packed {
		logic                    kind;
		logic [VOLT_W-1:0]       ch1_voltage_mv;
		logic signed [CUR_W-1:0] ch1_current_ma;
		logic [VOLT_W-1:0]       ch2_voltage_mv;
		logic signed [CUR_W-1:0] ch2_current_ma;
		logic [VOLT_W-1:0]       ch3_voltage_mv;
		logic signed [CUR_W-1:0] ch3_current_ma;
	} meas_item_t;

	typedef struct packed {
		logic              item_kind;
		logic [1:0]        channel;
		logic [1:0]        source_channel;
		logic [VOLT_W-1:0] source_voltage_mv;
		logic [19:0]       total_power_x100;
		logic [15:0]       charge_mah;
		logic [9:0]        channel_power_x10;
		logic [5:0]        current_bar_width;
		logic [5:0]        power_bar_width;
		logic              idle;
		logic [5:0]        anim_pos;
		logic              last;
	} result_item_t;

endpackage

/* design/tcpcm_chan_if.sv */
interface tcpcm_chan_if #(parameter type item_t = logic);
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* design/three_channel_power_charge_meter.sv */
// Flow: a tick's summary result is offered from the output stage once the tick has passed stages
//   1 to 5; its three column results follow one a cycle while the sink takes them.
// While a tick's four result beats hold the output stage, the stages behind it fill and then stall;
//   a clear item gives no result. Up to six items wait in the pipe.
// Reset: asynchronous, active low. Clears pipe valids, charge and animation state, and loads
//   the thresholds with 3000 mV (source detect) and 1000 mV (idle).
module three_channel_power_charge_meter
	import tcpcm_pkg::*;
#(
	parameter int BAR_WIDTH     = 45,
	parameter int SEGMENT_WIDTH = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	tcpcm_chan_if.sink           meas,
	tcpcm_chan_if.source         result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	// bar arithmetic widths follow the bar width
	localparam int BWW      = $clog2(BAR_WIDTH + 1);
	localparam int ABW_W    = $clog2(CURRENT_FULL_MA) + BWW;   // |i| * BAR_WIDTH, |i| < 10000
	localparam int CW_SHIFT = ABW_W + $clog2(CURRENT_FULL_MA);
	localparam logic [ABW_W:0] CW_RECIP = (ABW_W+1)'(((64'd1 << CW_SHIFT)
		+ 64'(CURRENT_FULL_MA) - 64'd1) / 64'(CURRENT_FULL_MA));
	localparam int PBW_W    = 10 + BWW;                        // clamped W*10 times BAR_WIDTH
	localparam int PW_SHIFT = PBW_W + $clog2(POWER_FULL_X10);
	localparam logic [PBW_W:0] PW_RECIP = (PBW_W+1)'(((64'd1 << PW_SHIFT)
		+ 64'(POWER_FULL_X10) - 64'd1) / 64'(POWER_FULL_X10));

	// ping-pong animation
	localparam int TRAVEL = (SEGMENT_WIDTH < BAR_WIDTH) ? BAR_WIDTH - SEGMENT_WIDTH : 0;
	localparam int FRAMES = 2 * TRAVEL;
	localparam int AW     = (FRAMES > 1) ? $clog2(FRAMES) : 1;

	localparam logic [1:0] BEAT_LAST = 2'd3;

	// ---------------------------------------------------------------- config
	logic [CFG_W-1:0] detect_q, idle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			detect_q <= SOURCE_DETECT_RESET;
			idle_q   <= IDLE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SOURCE_DETECT: detect_q <= cfg_wdata;
				REG_IDLE:          idle_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- flow control
	// Elastic pipe: a stage takes a new item when empty or when its item moves on.
	// Clear items drop out at the output stage.
	logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid, ob_valid_q;
	logic [1:0] beat_q;
	logic en1, en2, en3, en4, en5, en6, ob_take;

	assign ob_take    = ob_valid_q && result.ready && (beat_q == BEAT_LAST);
	assign en6        = !ob_valid_q || ob_take;
	assign en5        = !s5_valid || en6;
	assign en4        = !s4_valid || en5;
	assign en3        = !s3_valid || en4;
	assign en2        = !s2_valid || en3;
	assign en1        = !s1_valid || en2;
	assign meas.ready = en1;

	// ---------------------------------------------------------------- stage 1: input
	meas_item_t s1_item;

	always_ff @(posedge clk) begin
		if (en1) s1_item <= meas.data;
	end

	// ---------------------------------------------------------------- stage 2
	// |i|, v*|i|, source pick, idle flags, |i|*BAR_WIDTH
	logic [VOLT_W-1:0] v1 [3];
	logic [CUR_W-1:0]  i1 [3];
	logic [CUR_W-1:0]  amag [3];
	logic [2:0]        neg;
	logic [PROD_W-1:0] c2_prod [3];
	logic [ABW_W-1:0]  c2_abw [3];
	logic [2:0]        c2_cfull, c2_idle, c2_sel;
	logic [1:0]        c2_src;
	logic [VOLT_W-1:0] c2_srcv;
	logic [CUR_W-1:0]  c2_amag_src;

	always_comb begin
		v1[0] = s1_item.ch1_voltage_mv;
		v1[1] = s1_item.ch2_voltage_mv;
		v1[2] = s1_item.ch3_voltage_mv;
		i1[0] = s1_item.ch1_current_ma;
		i1[1] = s1_item.ch2_current_ma;
		i1[2] = s1_item.ch3_current_ma;
		for (int k = 0; k < 3; k++) begin
			neg[k]      = i1[k][CUR_W-1];
			// -32768 gives 32768, which still fits unsigned
			amag[k]     = neg[k] ? (~i1[k] + 16'd1) : i1[k];
			c2_prod[k]  = PROD_W'(v1[k]) * PROD_W'(amag[k]);
			c2_cfull[k] = amag[k] >= 16'(CURRENT_FULL_MA);
			c2_abw[k]   = ABW_W'(amag[k]) * ABW_W'(BAR_WIDTH);
			c2_idle[k]  = v1[k] < idle_q;
		end
		// last negative of ch1/ch2 wins; ch3 only when neither feeds
		c2_sel      = 3'b000;
		c2_src      = SRC_NONE;
		c2_srcv     = '0;
		c2_amag_src = '0;
		if (neg[0]) begin
			c2_sel[0]   = 1'b1;
			c2_src      = SRC_CH1;
			c2_srcv     = v1[0];
			c2_amag_src = amag[0];
		end
		if (neg[1]) begin
			c2_sel[1]   = 1'b1;
			c2_src      = SRC_CH2;
			c2_srcv     = v1[1];
			c2_amag_src = amag[1];
		end
		if (!neg[0] && !neg[1] && (v1[2] >= detect_q)) begin
			c2_sel[2]   = 1'b1;
			c2_src      = SRC_CH3;
			c2_srcv     = v1[2];
			c2_amag_src = amag[2];
		end
	end

	logic              s2_kind;
	logic [PROD_W-1:0] s2_prod [3];
	logic [ABW_W-1:0]  s2_abw [3];
	logic [2:0]        s2_cfull, s2_idle, s2_sel;
	logic [1:0]        s2_src;
	logic [VOLT_W-1:0] s2_srcv;
	logic [CUR_W-1:0]  s2_amag_src;

	always_ff @(posedge clk) begin
		if (en2) begin
			s2_kind     <= s1_item.kind;
			s2_prod     <= c2_prod;
			s2_abw      <= c2_abw;
			s2_cfull    <= c2_cfull;
			s2_idle     <= c2_idle;
			s2_sel      <= c2_sel;
			s2_src      <= c2_src;
			s2_srcv     <= c2_srcv;
			s2_amag_src <= c2_amag_src;
		end
	end

	// ---------------------------------------------------------------- stage 3
	// reciprocal multiplies: W*100 per channel, current bar, |i_src| / 5
	logic [2*PROD_W:0]  t_prod [3];
	logic [2*ABW_W:0]   cw_prod [3];
	logic [2*CUR_W:0]   q5_prod;
	logic [T_W-1:0]     c3_t [3];
	logic [BWW-1:0]     c3_cw [3];
	logic [QA_W-1:0]    c3_qa;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			t_prod[k]  = (2*PROD_W+1)'(s2_prod[k]) * (2*PROD_W+1)'(T_RECIP);
			c3_t[k]    = t_prod[k][T_SHIFT +: T_W];
			cw_prod[k] = (2*ABW_W+1)'(s2_abw[k]) * (2*ABW_W+1)'(CW_RECIP);
			c3_cw[k]   = s2_cfull[k] ? BWW'(BAR_WIDTH) : cw_prod[k][CW_SHIFT +: BWW];
		end
		q5_prod = (2*CUR_W+1)'(s2_amag_src) * (2*CUR_W+1)'(Q5_RECIP);
		c3_qa   = q5_prod[Q5_SHIFT +: QA_W];
	end

	logic              s3_kind;
	logic [T_W-1:0]    s3_t [3];
	logic [BWW-1:0]    s3_cw [3];
	logic [QA_W-1:0]   s3_qa;
	logic [2:0]        s3_alo, s3_idle, s3_sel;
	logic [1:0]        s3_src;
	logic [VOLT_W-1:0] s3_srcv;

	always_ff @(posedge clk) begin
		if (en3) begin
			s3_kind <= s2_kind;
			s3_t    <= c3_t;
			s3_cw   <= c3_cw;
			s3_qa   <= c3_qa;
			s3_alo  <= s2_amag_src[2:0];
			s3_idle <= s2_idle;
			s3_sel  <= s2_sel;
			s3_src  <= s2_src;
			s3_srcv <= s2_srcv;
		end
	end

	// ---------------------------------------------------------------- stage 4
	// total power, W*10 per channel, charge step with the fifth-mAs remainder
	logic [2:0]        charge_rem_q;
	logic [2*T_W:0]    p10_prod [3];
	logic [P10_W-1:0]  c4_p10 [3];
	logic [T_W:0]      tot_sum;
	logic [19:0]       c4_total;
	logic [2:0]        ra;
	logic [3:0]        rem_sum;
	logic              rem_carry;
	logic [2:0]        c4_rem_next;
	logic [QA_W-1:0]   c4_d;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			p10_prod[k] = (2*T_W+1)'(s3_t[k]) * (2*T_W+1)'(P10_RECIP);
			c4_p10[k]   = p10_prod[k][P10_SHIFT +: P10_W];
		end
		tot_sum = (s3_sel[0] ? (T_W+1)'(s3_t[0]) : '0)
			+ (s3_sel[1] ? (T_W+1)'(s3_t[1]) : '0)
			+ (s3_sel[2] ? (T_W+1)'(s3_t[2]) : '0);
		c4_total = (20'(tot_sum) > TOTAL_CLAMP) ? TOTAL_CLAMP : 20'(tot_sum);
		// |i| mod 5 from the low bits: |i| - 5*q, known to be 0..4
		ra          = s3_alo - (s3_qa[2:0] + {s3_qa[0], 2'b00});
		rem_sum     = {1'b0, charge_rem_q} + {1'b0, ra};
		rem_carry   = rem_sum >= 4'(TICKS_PER_S);
		c4_rem_next = rem_carry ? 3'(rem_sum - 4'(TICKS_PER_S)) : rem_sum[2:0];
		c4_d        = (s3_sel != 3'b000) ? (s3_qa + QA_W'(rem_carry)) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			charge_rem_q <= '0;
		end else if (en4 && s3_valid) begin
			if (s3_kind == KIND_CLEAR) charge_rem_q <= '0;
			else if (s3_sel != 3'b000) charge_rem_q <= c4_rem_next;
		end
	end

	logic              s4_kind;
	logic [19:0]       s4_total;
	logic [P10_W-1:0]  s4_p10 [3];
	logic [BWW-1:0]    s4_cw [3];
	logic [QA_W-1:0]   s4_d;
	logic [2:0]        s4_idle;
	logic [1:0]        s4_src;
	logic [VOLT_W-1:0] s4_srcv;

	always_ff @(posedge clk) begin
		if (en4) begin
			s4_kind  <= s3_kind;
			s4_total <= c4_total;
			s4_p10   <= c4_p10;
			s4_cw    <= s3_cw;
			s4_d     <= c4_d;
			s4_idle  <= s3_idle;
			s4_src   <= s3_src;
			s4_srcv  <= s3_srcv;
		end
	end

	// ---------------------------------------------------------------- stage 5
	// clamp channel power, power*BAR_WIDTH, charge in mAs kept as mAh quotient and
	// remainder so no 32-bit divide is needed, animation step
	logic [31:0]        mas_q;
	logic [MAH_Q_W-1:0] mah_q;
	logic [MAH_R_W-1:0] mas_frac_q;
	logic [AW-1:0]      anim_q;

	logic [9:0]         c5_p [3];
	logic [PBW_W-1:0]   c5_pbw [3];
	logic [32:0]        mas_sum;
	logic               mas_wrap;
	logic [13:0]        frac1;
	logic [MAH_R_W-1:0] frac2, frac3;
	logic [1:0]         qinc;
	logic [MAH_Q_W:0]   q2;
	logic [MAH_Q_W-1:0] q3;
	logic [AW-1:0]      anim_next;
	logic [AW:0]        c5_pos;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			c5_p[k]   = (s4_p10[k] > P10_W'(CHAN_CLAMP)) ? CHAN_CLAMP : 10'(s4_p10[k]);
			c5_pbw[k] = PBW_W'(c5_p[k]) * PBW_W'(BAR_WIDTH);
		end

		mas_sum  = {1'b0, mas_q} + 33'(s4_d);
		mas_wrap = mas_sum[32];
		frac1    = 14'(mas_frac_q) + 14'(s4_d);
		if (frac1 >= 14'(2 * MAS_PER_MAH)) begin
			qinc  = 2'd2;
			frac2 = MAH_R_W'(frac1 - 14'(2 * MAS_PER_MAH));
		end else if (frac1 >= 14'(MAS_PER_MAH)) begin
			qinc  = 2'd1;
			frac2 = MAH_R_W'(frac1 - 14'(MAS_PER_MAH));
		end else begin
			qinc  = 2'd0;
			frac2 = MAH_R_W'(frac1);
		end
		q2 = (MAH_Q_W+1)'(mah_q) + (MAH_Q_W+1)'(qinc);
		// mAs wraps at 2^32: take off 2^32 as its quotient and remainder of 3600
		if (!mas_wrap) begin
			frac3 = frac2;
			q3    = MAH_Q_W'(q2);
		end else if (frac2 >= MAH_R_W'(WRAP_R)) begin
			frac3 = frac2 - MAH_R_W'(WRAP_R);
			q3    = MAH_Q_W'(q2 - (MAH_Q_W+1)'(WRAP_Q));
		end else begin
			frac3 = frac2 + MAH_R_W'(MAS_PER_MAH - WRAP_R);
			q3    = MAH_Q_W'(q2 - (MAH_Q_W+1)'(WRAP_Q) - (MAH_Q_W+1)'(1));
		end

		if (FRAMES == 0) anim_next = '0;
		else if (anim_q == AW'(FRAMES - 1)) anim_next = '0;
		else anim_next = anim_q + AW'(1);
		c5_pos = (anim_next <= AW'(TRAVEL)) ? {1'b0, anim_next}
			: ((AW+1)'(FRAMES) - {1'b0, anim_next});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mas_q      <= '0;
			mah_q      <= '0;
			mas_frac_q <= '0;
			anim_q     <= '0;
		end else if (en5 && s4_valid) begin
			if (s4_kind == KIND_CLEAR) begin
				mas_q      <= '0;
				mah_q      <= '0;
				mas_frac_q <= '0;
			end else begin
				mas_q      <= mas_sum[31:0];
				mah_q      <= q3;
				mas_frac_q <= frac3;
				anim_q     <= anim_next;
			end
		end
	end

	logic              s5_kind;
	logic [19:0]       s5_total;
	logic [9:0]        s5_p [3];
	logic [PBW_W-1:0]  s5_pbw [3];
	logic [BWW-1:0]    s5_cw [3];
	logic [15:0]       s5_mah;
	logic [AW:0]       s5_pos;
	logic [2:0]        s5_idle;
	logic [1:0]        s5_src;
	logic [VOLT_W-1:0] s5_srcv;

	always_ff @(posedge clk) begin
		if (en5) begin
			s5_kind  <= s4_kind;
			s5_total <= s4_total;
			s5_p     <= c5_p;
			s5_pbw   <= c5_pbw;
			s5_cw    <= s4_cw;
			s5_mah   <= q3[15:0];
			s5_pos   <= c5_pos;
			s5_idle  <= s4_idle;
			s5_src   <= s4_src;
			s5_srcv  <= s4_srcv;
		end
	end

	// ---------------------------------------------------------------- output stage
	// power bar width; p <= 999 keeps it below BAR_WIDTH, so no clamp
	logic [2*PBW_W:0] pw_prod [3];
	logic [BWW-1:0]   c6_pw [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			pw_prod[k] = (2*PBW_W+1)'(s5_pbw[k]) * (2*PBW_W+1)'(PW_RECIP);
			c6_pw[k]   = pw_prod[k][PW_SHIFT +: BWW];
		end
	end

	logic [19:0]       ob_total;
	logic [9:0]        ob_p [3];
	logic [BWW-1:0]    ob_pw [3];
	logic [BWW-1:0]    ob_cw [3];
	logic [15:0]       ob_mah;
	logic [AW:0]       ob_pos;
	logic [2:0]        ob_idle;
	logic [1:0]        ob_src;
	logic [VOLT_W-1:0] ob_srcv;

	always_ff @(posedge clk) begin
		if (en6) begin
			ob_total <= s5_total;
			ob_p     <= s5_p;
			ob_pw    <= c6_pw;
			ob_cw    <= s5_cw;
			ob_mah   <= s5_mah;
			ob_pos   <= s5_pos;
			ob_idle  <= s5_idle;
			ob_src   <= s5_src;
			ob_srcv  <= s5_srcv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid   <= 1'b0;
			s2_valid   <= 1'b0;
			s3_valid   <= 1'b0;
			s4_valid   <= 1'b0;
			s5_valid   <= 1'b0;
			ob_valid_q <= 1'b0;
			beat_q     <= '0;
		end else begin
			if (en1) s1_valid <= meas.valid;
			if (en2) s2_valid <= s1_valid;
			if (en3) s3_valid <= s2_valid;
			if (en4) s4_valid <= s3_valid;
			if (en5) s5_valid <= s4_valid;
			if (en6) begin
				ob_valid_q <= s5_valid && (s5_kind == KIND_TICK);
				beat_q     <= '0;
			end else if (result.ready) begin
				beat_q <= beat_q + 2'd1;
			end
		end
	end

	// beat 0 summary, then columns ch3, ch2, ch1
	result_item_t res;
	logic [1:0]   col;

	always_comb begin
		res = '0;
		col = SRC_CH1;
		case (beat_q)
			2'd0: col = SRC_CH1;
			2'd1: col = SRC_CH3;
			2'd2: col = SRC_CH2;
			2'd3: col = SRC_CH1;
			default: col = SRC_CH1;
		endcase
		if (beat_q == 2'd0) begin
			res.item_kind         = RES_SUMMARY;
			res.source_channel    = ob_src;
			res.source_voltage_mv = ob_srcv;
			res.total_power_x100  = ob_total;
			res.charge_mah        = ob_mah;
		end else begin
			res.item_kind         = RES_COLUMN;
			res.channel           = col;
			res.channel_power_x10 = ob_p[col];
			res.current_bar_width = 6'(ob_cw[col]);
			res.power_bar_width   = 6'(ob_pw[col]);
			res.idle              = ob_idle[col];
			res.anim_pos          = 6'(ob_pos);
			res.last              = beat_q == BEAT_LAST;
		end
	end

	assign result.valid = ob_valid_q;
	assign result.data  = res;

	// ---------------------------------------------------------------- checks
	// a tick's four results leave without gaps
	a_beats_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.ready && !result.data.last |=> result.valid)
		else $error("result beats of one tick broke up");

	// quotient and remainder of 3600 always rebuild the mAs count
	a_mah_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(mah_q) * 32'(MAS_PER_MAH) + 32'(mas_frac_q)) == mas_q)
		else $error("mAh quotient out of step with mAs");

	// both remainders stay below their divisors
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(charge_rem_q < 3'(TICKS_PER_S)) && (mas_frac_q < MAH_R_W'(MAS_PER_MAH)))
		else $error("charge remainder out of range");

endmodule
